FILE: sv/zmap_conjunction_accumulator_top_macros.svh
// assertion macros for the z-map conjunction accumulator
`ifndef ZMAP_CONJUNCTION_ACCUMULATOR_TOP_MACROS_SVH
`define ZMAP_CONJUNCTION_ACCUMULATOR_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define ZCA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zca check failed");

// next-cycle implication, clocked on clk, off during reset
`define ZCA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zca check failed");

`endif

FILE: sv/zca_pkg.sv
package zca_pkg;

    localparam int VOXELS_DEF = 65536;
    localparam int DATA_WIDTH = 16;
    localparam int MAX_IMAGES = 127;

    localparam int VOX_W  = 16;
    localparam int MAG_W  = DATA_WIDTH - 1;
    localparam int CNT_W  = 7;
    localparam int SIGN_W = 8;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_IMAGES);
    localparam logic signed [SIGN_W-1:0] SIGN_MAX = SIGN_W'(MAX_IMAGES);
    localparam logic signed [SIGN_W-1:0] SIGN_MIN = -SIGN_W'(MAX_IMAGES);

    localparam logic signed [DATA_WIDTH-1:0] POS_THR_RST = 16'sd768;
    localparam logic signed [DATA_WIDTH-1:0] NEG_THR_RST = -16'sd32768;
    localparam logic [CNT_W-1:0] IMG_TOTAL_RST = 7'd1;

    typedef enum logic [IDX_W-1:0] {
        CFG_MODE        = 2'd0,
        CFG_POS_THR     = 2'd1,
        CFG_NEG_THR     = 2'd2,
        CFG_IMAGE_TOTAL = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        MODE_COUNT = 1'b0,
        MODE_CONJ  = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t                          mode;
        logic signed [DATA_WIDTH-1:0]   pos_thr;
        logic signed [DATA_WIDTH-1:0]   neg_thr;
        logic [CNT_W-1:0]               image_total;
    } cfg_t;

endpackage

FILE: sv/zca_ram.sv
module zca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    clk,
    we,
    waddr,
    wdata,
    re,
    raddr,
    rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic             clk;
    input  logic             we;
    input  logic [AW-1:0]    waddr;
    input  logic [WIDTH-1:0] wdata;
    input  logic             re;
    input  logic [AW-1:0]    raddr;
    output logic [WIDTH-1:0] rdata;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/zca_regs.sv
module zca_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [zca_pkg::IDX_W-1:0]   cfg_index,
    input  logic [zca_pkg::CFG_W-1:0]   cfg_wdata,
    output zca_pkg::cfg_t               cfg
);
    import zca_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MODE:        cfg_next.mode        = mode_t'(cfg_wdata[0]);
                CFG_POS_THR:     cfg_next.pos_thr     = $signed(cfg_wdata[DATA_WIDTH-1:0]);
                CFG_NEG_THR:     cfg_next.neg_thr     = $signed(cfg_wdata[DATA_WIDTH-1:0]);
                CFG_IMAGE_TOTAL: cfg_next.image_total = cfg_wdata[CNT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode        <= MODE_COUNT;
            cfg_reg.pos_thr     <= POS_THR_RST;
            cfg_reg.neg_thr     <= NEG_THR_RST;
            cfg_reg.image_total <= IMG_TOTAL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/zca_update.sv
module zca_update (
    input  zca_pkg::cfg_t                               cfg,
    input  logic                                        first_image,
    input  logic signed [zca_pkg::DATA_WIDTH-1:0]       z_value,
    input  logic [zca_pkg::MAG_W-1:0]                   acc_rd,
    input  logic signed [zca_pkg::SIGN_W-1:0]           sign_rd,
    output logic [zca_pkg::MAG_W-1:0]                   acc_wr,
    output logic signed [zca_pkg::SIGN_W-1:0]           sign_wr,
    output logic [zca_pkg::CNT_W-1:0]                   hit_count,
    output logic signed [zca_pkg::DATA_WIDTH-1:0]       conj_value
);
    import zca_pkg::*;

    logic [CNT_W-1:0]               cnt_in;
    logic                           crossing;
    logic [CNT_W-1:0]               cnt_out;
    logic [MAG_W-1:0]               mag_in;
    logic signed [SIGN_W-1:0]       sg_in;
    logic signed [SIGN_W-1:0]       sg_out;
    logic [DATA_WIDTH-1:0]          abs_z;
    logic [MAG_W-1:0]               abs_sat;
    logic [MAG_W-1:0]               mag_out;
    logic [SIGN_W-1:0]              abs_sg;
    logic signed [DATA_WIDTH-1:0]   mag_signed;
    logic                           z_pos;
    logic                           z_neg;

    // count mode
    always_comb
    begin
        if (first_image)
        begin
            cnt_in = '0;
        end
        else if (acc_rd > MAG_W'(CNT_MAX))
        begin
            cnt_in = CNT_MAX;
        end
        else
        begin
            cnt_in = acc_rd[CNT_W-1:0];
        end
        crossing = (z_value >= cfg.pos_thr) || (z_value <= cfg.neg_thr);
        cnt_out  = (crossing && (cnt_in < CNT_MAX)) ? cnt_in + 1'b1 : cnt_in;
    end

    // conjunction mode
    always_comb
    begin
        z_neg   = z_value[DATA_WIDTH-1];
        z_pos   = !z_neg && (z_value != '0);
        mag_in  = first_image ? MAG_MAX : acc_rd;
        sg_in   = first_image ? '0 : sign_rd;
        sg_out  = sg_in;
        if (z_pos && (sg_in < SIGN_MAX))
        begin
            sg_out = sg_in + SIGN_W'(1);
        end
        if (z_neg && (sg_in > SIGN_MIN))
        begin
            sg_out = sg_in - SIGN_W'(1);
        end
        abs_z   = z_neg ? (~z_value + 1'b1) : z_value;
        abs_sat = abs_z[DATA_WIDTH-1] ? MAG_MAX : abs_z[MAG_W-1:0];
        mag_out = (abs_sat < mag_in) ? abs_sat : mag_in;
        abs_sg  = sg_out[SIGN_W-1] ? (~sg_out + 1'b1) : sg_out;
        mag_signed = $signed({1'b0, mag_out});
        if (abs_sg < SIGN_W'(cfg.image_total))
        begin
            conj_value = '0;
        end
        else if (sg_out[SIGN_W-1])
        begin
            conj_value = -mag_signed;
        end
        else
        begin
            conj_value = mag_signed;
        end
    end

    assign acc_wr    = (cfg.mode == MODE_COUNT) ? MAG_W'(cnt_out) : mag_out;
    assign sign_wr   = sg_out;
    assign hit_count = cnt_out;

endmodule

FILE: sv/zmap_conjunction_accumulator_top.sv
// z-map conjunction accumulator
// input items on s_axis: voxel index and q8.8 z value in tdata, tuser marks the
// first image of the series (entry starts afresh), tlast marks the last image
// (a result item follows). output items on m_axis carry voxel, hit count (count
// mode) or signed conjunction minimum (conjunction mode), the other field zero.
// configuration through cfg_we/cfg_index/cfg_wdata, to be written only while
// idle, not enforced by the block. one item per cycle sustained unless the
// output stalls. an item is read from the two stores at accept, updated and
// written back as it leaves the update stage; a one-entry forwarding register
// per store covers an item that follows one for the same voxel directly.
// items with a voxel index beyond the store depth are dropped silently.
// reset clears the pipeline and sets the registers to their defaults; store
// contents are undefined until an item with the first-image flag writes them,
// so there is no clearing pass.
// when m_axis_tready is low the output register holds its item, a last-image
// item in the update stage waits behind it, and s_axis_tready drops until then.
`include "zmap_conjunction_accumulator_top_macros.svh"

module zmap_conjunction_accumulator_top #(
    parameter int VOXELS = zca_pkg::VOXELS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,   // voxel_index, z_value
    input  logic                        s_axis_tuser,   // first_image
    input  logic                        s_axis_tlast,   // last_image
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [39:0]                 m_axis_tdata,   // out_voxel, hit_count, conj_value
    input  logic                        cfg_we,
    input  logic [zca_pkg::IDX_W-1:0]   cfg_index,
    input  logic [zca_pkg::CFG_W-1:0]   cfg_wdata
);
    import zca_pkg::*;

    localparam int AW = (VOXELS > 1) ? $clog2(VOXELS) : 1;

    cfg_t                           cfg;
    logic                           in_acc;
    logic [VOX_W-1:0]               in_vox;
    logic                           in_range;

    logic                           s1_valid_reg;
    logic [VOX_W-1:0]               s1_vox_reg;
    logic signed [DATA_WIDTH-1:0]   s1_z_reg;
    logic                           s1_first_reg;
    logic                           s1_last_reg;
    logic                           s1_inrange_reg;
    logic                           s1_emits;
    logic                           s1_adv;
    logic [AW-1:0]                  s1_addr;

    logic [MAG_W-1:0]               acc_ram_rd;
    logic [SIGN_W-1:0]              sign_ram_rd;
    logic [MAG_W-1:0]               acc_rd;
    logic signed [SIGN_W-1:0]       sign_rd;
    logic [MAG_W-1:0]               acc_wr;
    logic signed [SIGN_W-1:0]       sign_wr;
    logic                           acc_we;
    logic                           sign_we;
    logic [CNT_W-1:0]               upd_hits;
    logic signed [DATA_WIDTH-1:0]   upd_conj;

    logic                           acc_fwd_valid_reg;
    logic [AW-1:0]                  acc_fwd_addr_reg;
    logic [MAG_W-1:0]               acc_fwd_data_reg;
    logic                           sign_fwd_valid_reg;
    logic [AW-1:0]                  sign_fwd_addr_reg;
    logic signed [SIGN_W-1:0]       sign_fwd_data_reg;

    logic                           m_valid_reg;
    logic [39:0]                    m_data_reg;
    logic [39:0]                    m_data_next;

    zca_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign in_vox   = s_axis_tdata[VOX_W-1:0];
    assign in_range = (32'(in_vox) < 32'(VOXELS));
    assign s1_addr  = AW'(s1_vox_reg);

    assign s1_emits      = s1_last_reg && s1_inrange_reg;
    assign s1_adv        = s1_valid_reg && (!s1_emits || !m_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign acc_we  = s1_adv && s1_inrange_reg;
    assign sign_we = acc_we && (cfg.mode == MODE_CONJ);

    zca_ram #(
        .WIDTH (MAG_W),
        .DEPTH (VOXELS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (s1_addr),
        .wdata (acc_wr),
        .re    (in_acc),
        .raddr (AW'(in_vox)),
        .rdata (acc_ram_rd)
    );

    zca_ram #(
        .WIDTH (SIGN_W),
        .DEPTH (VOXELS)
    ) u_sign_ram (
        .clk   (clk),
        .we    (sign_we),
        .waddr (s1_addr),
        .wdata (sign_wr),
        .re    (in_acc),
        .raddr (AW'(in_vox)),
        .rdata (sign_ram_rd)
    );

    // forwarding covers the write landing at the same edge as the read
    assign acc_rd  = (acc_fwd_valid_reg && (acc_fwd_addr_reg == s1_addr))
                   ? acc_fwd_data_reg : acc_ram_rd;
    assign sign_rd = (sign_fwd_valid_reg && (sign_fwd_addr_reg == s1_addr))
                   ? sign_fwd_data_reg : $signed(sign_ram_rd);

    zca_update u_update (
        .cfg         (cfg),
        .first_image (s1_first_reg),
        .z_value     (s1_z_reg),
        .acc_rd      (acc_rd),
        .sign_rd     (sign_rd),
        .acc_wr      (acc_wr),
        .sign_wr     (sign_wr),
        .hit_count   (upd_hits),
        .conj_value  (upd_conj)
    );

    always_comb
    begin
        m_data_next = '0;
        m_data_next[VOX_W-1:0] = s1_vox_reg;
        if (cfg.mode == MODE_COUNT)
        begin
            m_data_next[VOX_W+CNT_W-1:VOX_W] = upd_hits;
        end
        else
        begin
            m_data_next[VOX_W+CNT_W+DATA_WIDTH-1:VOX_W+CNT_W] = upd_conj;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            acc_fwd_valid_reg  <= 1'b0;
            sign_fwd_valid_reg <= 1'b0;
            m_valid_reg        <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (acc_we)
            begin
                acc_fwd_valid_reg <= 1'b1;
            end
            if (sign_we)
            begin
                sign_fwd_valid_reg <= 1'b1;
            end
            if (s1_adv && s1_emits)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_vox_reg     <= in_vox;
            s1_z_reg       <= $signed(s_axis_tdata[VOX_W+DATA_WIDTH-1:VOX_W]);
            s1_first_reg   <= s_axis_tuser;
            s1_last_reg    <= s_axis_tlast;
            s1_inrange_reg <= in_range;
        end
        if (acc_we)
        begin
            acc_fwd_addr_reg <= s1_addr;
            acc_fwd_data_reg <= acc_wr;
        end
        if (sign_we)
        begin
            sign_fwd_addr_reg <= s1_addr;
            sign_fwd_data_reg <= sign_wr;
        end
        if (s1_adv && s1_emits)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    `ZCA_ASSERT_NOW(a_stall_blocks_input, s1_valid_reg && !s1_adv, !s_axis_tready)
    `ZCA_ASSERT_NOW(a_write_only_on_advance, acc_we || sign_we, s1_adv)
    `ZCA_ASSERT_NEXT(a_fwd_tracks_write, acc_we, acc_fwd_valid_reg && (acc_fwd_addr_reg == $past(s1_addr)))
    `ZCA_ASSERT_NOW(a_result_from_last, $rose(m_axis_tvalid), $past(s1_adv && s1_last_reg && s1_inrange_reg))

endmodule
